// ===== rtl/pbrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrt_pkg
// Shared types and constants of the pulse beat-rate tracker.
// ----------------------------------------------------------------------------
package pbrt_pkg;

	localparam int SAMPLE_DEPTH_DEF = 512;
	localparam int RATE_DEPTH_DEF   = 64;
	localparam int BEAT_WINDOW_DEF  = 8;

	// 60000 * (BEAT_WINDOW - 1) fits in 21 bits for windows up to 32 beats
	localparam int BPM_NUM_W = 21;
	localparam int BPM_SCALE = 60000;
	localparam logic [10:0] BPM_CAP = 11'd2047;

	localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
	localparam logic signed [15:0] S16_MIN = -16'sh8000;

	// register indexes of the configuration port
	localparam logic [1:0] REG_UPPER  = 2'd0;
	localparam logic [1:0] REG_LOWER  = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;
	localparam logic [1:0] REG_REFR   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DROP,
		S_SCAN,
		S_SWR,
		S_BEAT,
		S_BRD,
		S_DIVST,
		S_DIV,
		S_RATE,
		S_RSCAN,
		S_RWR,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [BPM_NUM_W-1:0] num;
		logic [31:0]          den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [BPM_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== rtl/pbrt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrt_div
// Restoring divider, one quotient bit per cycle, for the BPM computation.
// ----------------------------------------------------------------------------
module pbrt_div
	import pbrt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(BPM_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [BPM_NUM_W-1:0] num_q;
	logic [BPM_NUM_W-1:0] quo_q;
	logic [31:0]          den_q;
	logic [31:0]          rem_q;
	logic [32:0]          trial;
	logic                 fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, num_q[BPM_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BPM_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[BPM_NUM_W-2:0], 1'b0};
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[BPM_NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== rtl/pulse_beat_rate_tracker_core.sv =====
`timescale 1ns / 1ps
// Sequence: an accepted sample passes S_SWR, S_BEAT, S_FIN and S_OUT; S_DROP drops the oldest sample
// once the window is full, and S_SCAN rescans the window when that drop forces a rescan.
// A beat that yields a BPM adds S_BRD, S_DIVST, S_DIV (the divider) and S_RATE, without S_DIV on a zero span;
// a rate-history rescan adds S_RSCAN, and S_RWR writes the rate history.
// Flow: one sample at a time; a new sample is taken only in S_IDLE, after the last one reached the output.
// Reset: counts, heads and min/max clear at once; memories are not cleared.
// ----------------------------------------------------------------------------
// pulse_beat_rate_tracker_core
// Clamps pulse samples, tracks windowed min/max, detects beats and keeps a
// BPM history with its own min/max; the windows and the history are held in synchronous memories.
// ----------------------------------------------------------------------------
module pulse_beat_rate_tracker_core
	import pbrt_pkg::*;
#(
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
	parameter int RATE_DEPTH   = RATE_DEPTH_DEF,
	parameter int BEAT_WINDOW  = BEAT_WINDOW_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// sample[15:0], time_ms[47:16]
	input  logic [47:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// clamped_sample[15:0], window_oldest_time[47:16], window_min[63:48],
	// window_max[79:64], beat_found[80], rate_bpm[91:81], rate_valid[92],
	// rate_min[103:93], rate_max[114:104], rate_oldest_time[146:115],
	// rate_newest_time[178:147], zero fill above
	output logic [183:0] m_axis_tdata
);

	localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int SCW = $clog2(SAMPLE_DEPTH + 1);
	localparam int RD1 = RATE_DEPTH + 1;
	localparam int RAW = $clog2(RD1);
	localparam int RCW = $clog2(RD1 + 1);
	localparam int BAW = $clog2(BEAT_WINDOW);
	localparam int BCW = $clog2(BEAT_WINDOW + 1);

	// configuration registers
	logic signed [15:0] upper_q, lower_q, thresh_q;
	logic [15:0]        refr_q;

	state_t state_q, state_d;

	// item registers
	logic signed [15:0] s_q;
	logic [31:0]        t_q;
	logic               beat_q;
	logic [10:0]        bpm_q;

	// sample window
	logic signed [15:0] smem [SAMPLE_DEPTH];
	logic [31:0]        stmem [SAMPLE_DEPTH];
	logic signed [15:0] smem_rd_q;
	logic [31:0]        stmem_rd_q;
	logic [SAW-1:0]     shead_q;
	logic [SCW-1:0]     scount_q;
	logic [SCW-1:0]     sc_iss_q;
	logic signed [15:0] smin_q, smax_q;

	// beat window
	logic [31:0]        bmem [BEAT_WINDOW];
	logic [31:0]        bmem_rd_q;
	logic [BAW-1:0]     bhead_q;
	logic [BCW-1:0]     bcount_q;

	// rate history
	logic [10:0]        rmem [RD1];
	logic [31:0]        rtmem [RD1];
	logic [10:0]        rmem_rd_q;
	logic [31:0]        rtmem_rd_q;
	logic [RAW-1:0]     rhead_q;
	logic [RCW-1:0]     rcount_q;
	logic [RCW-1:0]     rc_iss_q;
	logic [10:0]        rlo_q, rhi_q, last_bpm_q;
	logic [31:0]        rnew_q;

	logic               rdv_q;

	// output register
	logic               out_valid_q;
	logic [183:0]       out_data_q;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// clamp of the incoming sample: upper first, lower wins
	logic signed [15:0] in_s, clamp_hi, clamp_s;
	assign in_s     = s_axis_tdata[15:0];
	assign clamp_hi = (in_s > upper_q) ? upper_q : in_s;
	assign clamp_s  = (clamp_hi < lower_q) ? lower_q : clamp_hi;

	// sample memory addresses
	logic [SAW:0]   s_rsum, s_wsum;
	logic [SAW-1:0] s_ra, s_wa, s_head_inc;
	logic [SAW:0]   s_hsum;
	assign s_rsum = {1'b0, shead_q} + ((state_q == S_SCAN) ? (SAW+1)'(sc_iss_q) : '0);
	assign s_ra   = (s_rsum >= (SAW+1)'(SAMPLE_DEPTH)) ?
		SAW'(s_rsum - (SAW+1)'(SAMPLE_DEPTH)) : s_rsum[SAW-1:0];
	assign s_wsum = {1'b0, shead_q} + (SAW+1)'(scount_q);
	assign s_wa   = (s_wsum >= (SAW+1)'(SAMPLE_DEPTH)) ?
		SAW'(s_wsum - (SAW+1)'(SAMPLE_DEPTH)) : s_wsum[SAW-1:0];
	assign s_hsum = {1'b0, shead_q} + (SAW+1)'(1);
	assign s_head_inc = (s_hsum >= (SAW+1)'(SAMPLE_DEPTH)) ? '0 : s_hsum[SAW-1:0];

	// beat memory addresses
	logic [BCW-1:0] b_last_off;
	logic [BAW:0]   b_rsum, b_wsum, b_hsum;
	logic [BAW-1:0] b_ra, b_wa, b_head_inc;
	assign b_last_off = (bcount_q == '0) ? '0 : bcount_q - 1'b1;
	assign b_rsum = {1'b0, bhead_q} + ((state_q == S_SWR) ? (BAW+1)'(b_last_off) : '0);
	assign b_ra   = (b_rsum >= (BAW+1)'(BEAT_WINDOW)) ?
		BAW'(b_rsum - (BAW+1)'(BEAT_WINDOW)) : b_rsum[BAW-1:0];
	assign b_wsum = {1'b0, bhead_q} + (BAW+1)'(bcount_q);
	assign b_hsum = {1'b0, bhead_q} + (BAW+1)'(1);
	assign b_head_inc = (b_hsum >= (BAW+1)'(BEAT_WINDOW)) ? '0 : b_hsum[BAW-1:0];
	assign b_wa = (bcount_q >= BCW'(BEAT_WINDOW)) ? bhead_q :
		((b_wsum >= (BAW+1)'(BEAT_WINDOW)) ?
		BAW'(b_wsum - (BAW+1)'(BEAT_WINDOW)) : b_wsum[BAW-1:0]);

	// rate memory addresses
	logic [RAW:0]   r_rsum, r_wsum, r_hsum;
	logic [RAW-1:0] r_ra, r_wa, r_head_inc;
	assign r_rsum = {1'b0, rhead_q} + ((state_q == S_RSCAN) ? (RAW+1)'(rc_iss_q) : '0);
	assign r_ra   = (r_rsum >= (RAW+1)'(RD1)) ?
		RAW'(r_rsum - (RAW+1)'(RD1)) : r_rsum[RAW-1:0];
	assign r_wsum = {1'b0, rhead_q} + (RAW+1)'(rcount_q);
	assign r_wa   = (r_wsum >= (RAW+1)'(RD1)) ?
		RAW'(r_wsum - (RAW+1)'(RD1)) : r_wsum[RAW-1:0];
	assign r_hsum = {1'b0, rhead_q} + (RAW+1)'(1);
	assign r_head_inc = (r_hsum >= (RAW+1)'(RD1)) ? '0 : r_hsum[RAW-1:0];

	// decisions taken on memory read data
	logic        s_full, s_rescan, r_full, r_rescan;
	logic        beat_ok, b_multi;
	logic [31:0] span;
	logic        s_scan_done, r_scan_done, out_free;
	logic [BCW-1:0] b_newcount;

	assign s_full   = scount_q == SCW'(SAMPLE_DEPTH);
	assign s_rescan = (smem_rd_q <= smin_q) || (smem_rd_q >= smax_q);
	assign r_full   = rcount_q == RCW'(RD1);
	assign r_rescan = (rmem_rd_q <= rlo_q) || (rmem_rd_q >= rhi_q);
	assign beat_ok  = (s_q > thresh_q) &&
		((bcount_q == '0) || ((t_q - bmem_rd_q) > {16'd0, refr_q}));
	assign b_newcount = (bcount_q >= BCW'(BEAT_WINDOW)) ? bcount_q : bcount_q + 1'b1;
	assign b_multi  = b_newcount > BCW'(1);
	assign span     = t_q - bmem_rd_q;
	assign s_scan_done = (sc_iss_q == scount_q) && !rdv_q;
	assign r_scan_done = (rc_iss_q == rcount_q) && !rdv_q;
	assign out_free = !out_valid_q || m_axis_tready;

	// divider request
	assign div_req.start = (state_q == S_DIVST) && (span != 32'd0);
	assign div_req.num   = BPM_NUM_W'(32'(BPM_SCALE) * (32'(bcount_q) - 32'd1));
	assign div_req.den   = span;

	pbrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = s_full ? S_DROP : S_SWR;
			end
			S_DROP:  state_d = s_rescan ? S_SCAN : S_SWR;
			S_SCAN: begin
				if (s_scan_done) state_d = S_SWR;
			end
			S_SWR:   state_d = S_BEAT;
			S_BEAT:  state_d = (beat_ok && b_multi) ? S_BRD : S_FIN;
			S_BRD:   state_d = S_DIVST;
			S_DIVST: state_d = (span == 32'd0) ? S_RATE : S_DIV;
			S_DIV: begin
				if (div_rsp.done) state_d = S_RATE;
			end
			S_RATE: begin
				if (r_full) state_d = r_rescan ? S_RSCAN : S_RWR;
				else        state_d = S_RWR;
			end
			S_RSCAN: begin
				if (r_scan_done) state_d = S_RWR;
			end
			S_RWR:   state_d = S_FIN;
			S_FIN:   state_d = S_OUT;
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_axis_tready = state_q == S_IDLE;

	// memories: registered read every cycle, one write port each
	always_ff @(posedge clk) begin
		smem_rd_q  <= smem[s_ra];
		stmem_rd_q <= stmem[s_ra];
		if (state_q == S_SWR) begin
			smem[s_wa]  <= s_q;
			stmem[s_wa] <= t_q;
		end
	end

	always_ff @(posedge clk) begin
		bmem_rd_q <= bmem[b_ra];
		if (state_q == S_BEAT && beat_ok) bmem[b_wa] <= t_q;
	end

	always_ff @(posedge clk) begin
		rmem_rd_q  <= rmem[r_ra];
		rtmem_rd_q <= rtmem[r_ra];
		if (state_q == S_RWR) begin
			rmem[r_wa]  <= bpm_q;
			rtmem[r_wa] <= t_q;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			s_q <= clamp_s;
			t_q <= s_axis_tdata[47:16];
		end
		if (state_q == S_DIVST && span == 32'd0) bpm_q <= BPM_CAP;
		if (state_q == S_DIV && div_rsp.done) begin
			bpm_q <= (div_rsp.quo > BPM_NUM_W'(BPM_CAP)) ? BPM_CAP : div_rsp.quo[10:0];
		end
		if (state_q == S_RWR) rnew_q <= t_q;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= 16'sd1023;
			lower_q  <= 16'sd0;
			thresh_q <= 16'sd550;
			refr_q   <= 16'd250;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UPPER:  upper_q  <= cfg_data;
				REG_LOWER:  lower_q  <= cfg_data;
				REG_THRESH: thresh_q <= cfg_data;
				REG_REFR:   refr_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// window bookkeeping, scans and beat/rate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shead_q    <= '0;
			scount_q   <= '0;
			sc_iss_q   <= '0;
			smin_q     <= S16_MAX;
			smax_q     <= S16_MIN;
			bhead_q    <= '0;
			bcount_q   <= '0;
			beat_q     <= 1'b0;
			last_bpm_q <= '0;
			rhead_q    <= '0;
			rcount_q   <= '0;
			rc_iss_q   <= '0;
			rlo_q      <= BPM_CAP;
			rhi_q      <= '0;
			rdv_q      <= 1'b0;
		end else begin
			case (state_q)
				S_DROP: begin
					// drop the oldest sample, rescan if it sat on a bound
					shead_q  <= s_head_inc;
					scount_q <= scount_q - 1'b1;
					if (s_rescan) begin
						smin_q   <= S16_MAX;
						smax_q   <= S16_MIN;
						sc_iss_q <= '0;
						rdv_q    <= 1'b0;
					end
				end
				S_SCAN: begin
					rdv_q <= sc_iss_q < scount_q;
					if (sc_iss_q < scount_q) sc_iss_q <= sc_iss_q + 1'b1;
					if (rdv_q) begin
						if (smem_rd_q < smin_q) smin_q <= smem_rd_q;
						if (smem_rd_q > smax_q) smax_q <= smem_rd_q;
					end
				end
				S_SWR: begin
					scount_q <= scount_q + 1'b1;
					if (s_q < smin_q) smin_q <= s_q;
					if (s_q > smax_q) smax_q <= s_q;
					beat_q <= 1'b0;
				end
				S_BEAT: begin
					beat_q <= beat_ok;
					if (beat_ok) begin
						if (bcount_q >= BCW'(BEAT_WINDOW)) bhead_q <= b_head_inc;
						bcount_q <= b_newcount;
					end
				end
				S_RATE: begin
					last_bpm_q <= bpm_q;
					if (r_full) begin
						rhead_q  <= r_head_inc;
						rcount_q <= rcount_q - 1'b1;
						if (r_rescan) begin
							rlo_q    <= BPM_CAP;
							rhi_q    <= '0;
							rc_iss_q <= '0;
							rdv_q    <= 1'b0;
						end
					end
				end
				S_RSCAN: begin
					rdv_q <= rc_iss_q < rcount_q;
					if (rc_iss_q < rcount_q) rc_iss_q <= rc_iss_q + 1'b1;
					if (rdv_q) begin
						if (rmem_rd_q < rlo_q) rlo_q <= rmem_rd_q;
						if (rmem_rd_q > rhi_q) rhi_q <= rmem_rd_q;
					end
				end
				S_RWR: begin
					rcount_q <= rcount_q + 1'b1;
					if (bpm_q < rlo_q) rlo_q <= bpm_q;
					if (bpm_q > rhi_q) rhi_q <= bpm_q;
				end
				default: ;
			endcase
		end
	end

	// output register: hold the result until the transaction completes
	logic       r_valid;
	logic [183:0] result;
	assign r_valid = rcount_q != '0;
	assign result = {
		5'd0,
		r_valid ? rnew_q : 32'd0,
		r_valid ? rtmem_rd_q : 32'd0,
		r_valid ? rhi_q : 11'd0,
		r_valid ? rlo_q : 11'd0,
		r_valid,
		last_bpm_q,
		beat_q,
		smax_q,
		smin_q,
		stmem_rd_q,
		s_q
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) out_data_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_scount_range: assert property (@(posedge clk) disable iff (!arst_n)
		scount_q <= SCW'(SAMPLE_DEPTH))
		else $error("sample count beyond window depth");

	a_rcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= RCW'(RD1))
		else $error("rate count beyond history depth");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside of the divide wait");

	a_accept_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("new transaction taken while one is in flight");
`endif

endmodule

// ===== sim/pulse_beat_rate_tracker_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_beat_rate_tracker_core_test
// Drives pulse samples with timestamps into the tracker under several limit,
// threshold and refractory settings, predicts every result transaction and
// compares it field by field against the block's output stream.
// ----------------------------------------------------------------------------
module pulse_beat_rate_tracker_core_test
	import pbrt_pkg::*;
;

	localparam int SDEPTH = 512;
	localparam int RDEPTH = 64;
	localparam int BWIN   = 8;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [31:0]        tm;
		logic signed [15:0] smp;
	} pulse_item_t;

	typedef struct packed {
		logic [31:0]        r_new;
		logic [31:0]        r_old;
		logic [10:0]        r_max;
		logic [10:0]        r_min;
		logic               r_valid;
		logic [10:0]        bpm;
		logic               beat;
		logic signed [15:0] w_max;
		logic signed [15:0] w_min;
		logic [31:0]        w_old;
		logic signed [15:0] clamped;
	} tracker_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [15:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [183:0] m_axis_tdata;

	pulse_beat_rate_tracker_core dut (.*);

	// predictor state
	logic signed [15:0] upper_lim, lower_lim, beat_thr;
	logic [15:0]        refr_ms;
	logic signed [15:0] smp_ring [SDEPTH];
	logic [31:0]        smp_time [SDEPTH];
	int                 smp_head, smp_cnt;
	logic signed [15:0] smp_lo, smp_hi;
	logic [31:0]        beat_ring [BWIN];
	int                 beat_head, beat_cnt;
	logic [10:0]        last_bpm;
	logic [10:0]        bpm_ring [RDEPTH+1];
	logic [31:0]        bpm_time [RDEPTH+1];
	int                 bpm_head, bpm_cnt;
	logic [10:0]        bpm_lo, bpm_hi;

	pulse_item_t     pending_q [$];
	tracker_result_t expected_q [$];
	int              error_count;
	longint          cycle_count;
	bit              in_taken;
	int              send_gap, recv_gap;
	logic [31:0]     clock_ms;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		error_count++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	task automatic reset_tracker();
		upper_lim = 16'sd1023; lower_lim = 16'sd0; beat_thr = 16'sd550; refr_ms = 16'd250;
		smp_head = 0; smp_cnt = 0; smp_lo = S16_MAX; smp_hi = S16_MIN;
		beat_head = 0; beat_cnt = 0; last_bpm = '0;
		bpm_head = 0; bpm_cnt = 0; bpm_lo = BPM_CAP; bpm_hi = '0;
	endtask

	function automatic tracker_result_t track_pulse(input pulse_item_t it);
		tracker_result_t r;
		logic signed [15:0] s, dropped;
		logic [10:0] bdrop, bpm;
		logic [31:0] span, quo;
		bit accept;
		int w;
		s = it.smp;
		r = '0;
		if (s > upper_lim) s = upper_lim;
		if (s < lower_lim) s = lower_lim;
		// slide the sample window, rescan when a bound leaves
		if (smp_cnt >= SDEPTH) begin
			dropped = smp_ring[smp_head];
			smp_head = (smp_head + 1) % SDEPTH;
			smp_cnt--;
			if (dropped <= smp_lo || dropped >= smp_hi) begin
				smp_lo = S16_MAX; smp_hi = S16_MIN;
				for (int i = 0; i < smp_cnt; i++) begin
					if (smp_ring[(smp_head + i) % SDEPTH] < smp_lo)
						smp_lo = smp_ring[(smp_head + i) % SDEPTH];
					if (smp_ring[(smp_head + i) % SDEPTH] > smp_hi)
						smp_hi = smp_ring[(smp_head + i) % SDEPTH];
				end
			end
		end
		w = (smp_head + smp_cnt) % SDEPTH;
		smp_ring[w] = s; smp_time[w] = it.tm; smp_cnt++;
		if (s < smp_lo) smp_lo = s;
		if (s > smp_hi) smp_hi = s;
		// beat detection and rate history
		if (s > beat_thr) begin
			accept = (beat_cnt == 0);
			if (!accept)
				accept = (it.tm - beat_ring[(beat_head + beat_cnt - 1) % BWIN]) > {16'd0, refr_ms};
			if (accept) begin
				r.beat = 1'b1;
				if (beat_cnt >= BWIN) begin
					beat_ring[beat_head] = it.tm;
					beat_head = (beat_head + 1) % BWIN;
				end else begin
					beat_ring[(beat_head + beat_cnt) % BWIN] = it.tm;
					beat_cnt++;
				end
				if (beat_cnt > 1) begin
					span = it.tm - beat_ring[beat_head];
					quo = (span == 0) ? 32'd2047 : (32'd60000 * (beat_cnt - 1)) / span;
					bpm = (quo > 2047) ? BPM_CAP : quo[10:0];
					last_bpm = bpm;
					if (bpm_cnt > RDEPTH) begin
						bdrop = bpm_ring[bpm_head];
						bpm_head = (bpm_head + 1) % (RDEPTH + 1);
						bpm_cnt--;
						if (bdrop <= bpm_lo || bdrop >= bpm_hi) begin
							bpm_lo = BPM_CAP; bpm_hi = '0;
							for (int i = 0; i < bpm_cnt; i++) begin
								if (bpm_ring[(bpm_head + i) % (RDEPTH + 1)] < bpm_lo)
									bpm_lo = bpm_ring[(bpm_head + i) % (RDEPTH + 1)];
								if (bpm_ring[(bpm_head + i) % (RDEPTH + 1)] > bpm_hi)
									bpm_hi = bpm_ring[(bpm_head + i) % (RDEPTH + 1)];
							end
						end
					end
					w = (bpm_head + bpm_cnt) % (RDEPTH + 1);
					bpm_ring[w] = bpm; bpm_time[w] = it.tm; bpm_cnt++;
					if (bpm < bpm_lo) bpm_lo = bpm;
					if (bpm > bpm_hi) bpm_hi = bpm;
				end
			end
		end
		r.clamped = s;
		r.w_old = smp_time[smp_head];
		r.w_min = smp_lo;
		r.w_max = smp_hi;
		r.bpm = last_bpm;
		if (bpm_cnt > 0) begin
			r.r_valid = 1'b1;
			r.r_min = bpm_lo;
			r.r_max = bpm_hi;
			r.r_old = bpm_time[bpm_head];
			r.r_new = bpm_time[(bpm_head + bpm_cnt - 1) % (RDEPTH + 1)];
		end
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: present the next pending item, hold it until accepted
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				pending_q.delete(0);
				send_gap = pick_gap();
			end
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {pending_q[0].tm, pending_q[0].smp};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			// receiver stalls
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	// input monitor: predict on each accepted transaction
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_q.insert(expected_q.size(), track_pulse(pulse_item_t'(s_axis_tdata)));
			in_taken = 1'b1;
		end
	end

	// output monitor: compare each result transaction
	always @(posedge clk) begin
		tracker_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = tracker_result_t'(m_axis_tdata[178:0]);
			if (expected_q.size() == 0) begin
				error_count++;
				$display("unexpected result transaction");
			end else begin
				want = expected_q[0];
				expected_q.delete(0);
				if (got.clamped !== want.clamped) report_mismatch("clamped_sample", got.clamped, want.clamped);
				if (got.w_old !== want.w_old) report_mismatch("window_oldest_time", got.w_old, want.w_old);
				if (got.w_min !== want.w_min) report_mismatch("window_min", got.w_min, want.w_min);
				if (got.w_max !== want.w_max) report_mismatch("window_max", got.w_max, want.w_max);
				if (got.beat !== want.beat) report_mismatch("beat_found", got.beat, want.beat);
				if (got.bpm !== want.bpm) report_mismatch("rate_bpm", got.bpm, want.bpm);
				if (got.r_valid !== want.r_valid) report_mismatch("rate_valid", got.r_valid, want.r_valid);
				if (got.r_min !== want.r_min) report_mismatch("rate_min", got.r_min, want.r_min);
				if (got.r_max !== want.r_max) report_mismatch("rate_max", got.r_max, want.r_max);
				if (got.r_old !== want.r_old) report_mismatch("rate_oldest_time", got.r_old, want.r_old);
				if (got.r_new !== want.r_new) report_mismatch("rate_newest_time", got.r_new, want.r_new);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pulse_beat_rate_tracker_core_test failed");
			$finish;
		end
	end

	task automatic wait_drain();
		while (pending_q.size() > 0 || expected_q.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_UPPER:  upper_lim = val;
			REG_LOWER:  lower_lim = val;
			REG_THRESH: beat_thr = val;
			REG_REFR:   refr_ms = val;
			default:    ;
		endcase
	endtask

	task automatic add_item(input logic [15:0] s, input logic [31:0] t);
		pending_q.insert(pending_q.size(), pulse_item_t'{tm: t, smp: s});
	endtask

	// a run of pulse-like samples: beats spaced by a random period
	task automatic add_pulse_train(input int n, input int period, input logic [15:0] peak,
		input logic [15:0] base);
		for (int i = 0; i < n; i++) begin
			clock_ms += $urandom_range(1, 8);
			if ($urandom_range(0, 19) == 0)
				add_item(16'($urandom), clock_ms);
			else if ((i % period) == 0)
				add_item(16'(peak + $urandom_range(0, 50)), clock_ms);
			else
				add_item(16'(base + $urandom_range(0, 100)), clock_ms);
		end
	endtask

	initial begin
		int phase_items;
		error_count = 0; cycle_count = 0; in_taken = 1'b0;
		send_gap = 0; recv_gap = 0;
		cfg_we = 1'b0; cfg_index = REG_UPPER; cfg_data = '0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
		reset_tracker();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes and refractory at reset settings
		add_item(16'sh7FFF, 32'd0);
		add_item(16'sh8000, 32'hFFFF_FFFF);
		add_item(16'd0, 32'd100);
		add_item(16'd1023, 32'd101);
		add_item(16'd600, 32'd200);
		add_item(16'd600, 32'd450);
		add_item(16'd600, 32'd451);
		add_item(16'd551, 32'd1000);
		add_item(16'd550, 32'd2000);
		add_item(16'hFFFF, 32'h5555_5555);
		add_item(16'h5555, 32'hAAAA_AAAA);
		wait_drain();
		// crossed limits, zero refractory: equal timestamps are not taken as beats
		write_reg(REG_UPPER, 16'sh8000);
		write_reg(REG_LOWER, 16'sh7FFF);
		write_reg(REG_THRESH, 16'sh8000);
		write_reg(REG_REFR, 16'd0);
		add_item(16'd5, 32'd7000);
		add_item(16'd5, 32'd7001);
		add_item(16'd5, 32'd7001);
		add_item(16'hAAAA, 32'hFFFF_FFFE);
		add_item(16'h8000, 32'd3);
		add_item(16'd0, 32'd4);
		wait_drain();
		// wide open limits, maximum refractory, timestamp wrap
		write_reg(REG_UPPER, 16'sh7FFF);
		write_reg(REG_LOWER, 16'sh8000);
		write_reg(REG_THRESH, 16'sh7FFE);
		write_reg(REG_REFR, 16'hFFFF);
		add_item(16'sh7FFF, 32'hFFFF_0000);
		add_item(16'sh7FFF, 32'h0000_0001);
		add_item(16'sh7FFF, 32'h0000_0002);
		add_item(16'sh8000, 32'h0000_0003);
		wait_drain();

		// random phases of pulse trains with random settings
		clock_ms = $urandom;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_UPPER, (ph == 5) ? 16'sh7FFF : 16'(900 + $urandom_range(0, 300)));
			write_reg(REG_LOWER, (ph == 5) ? 16'sh8000 : 16'($urandom_range(0, 150)));
			write_reg(REG_THRESH, 16'($urandom_range(400, 700)));
			write_reg(REG_REFR, (ph == 4) ? 16'd0 : 16'($urandom_range(0, 400)));
			phase_items = (ph == 3) ? 560 : 90;
			add_pulse_train(phase_items, int'($urandom_range(20, 150)), 16'd800, 16'd200);
			wait_drain();
		end

		repeat (50) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0)
			$display("pulse_beat_rate_tracker_core_test passed");
		else
			$display("pulse_beat_rate_tracker_core_test failed");
		$finish;
	end

endmodule
